>>> rtl/lock_table_acquire_release_macros.svh
// Assertion macros used by the checker file of the lock table.
`ifndef LOCK_TABLE_ACQUIRE_RELEASE_MACROS_SVH
`define LOCK_TABLE_ACQUIRE_RELEASE_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is high.
`define LTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define LTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lta_pkg.sv
package lta_pkg;

  localparam int KEY_W   = 64;
  localparam int LEN_W   = 4;
  localparam int SINCE_W = 34;
  localparam int MAX_LEN = 8;

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    STATUS_ACQUIRED = 3'd0,
    STATUS_CONFLICT = 3'd1,
    STATUS_RELEASED = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_FORBIDDEN = 3'd4,
    STATUS_TABLE_FULL = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_PROBE,
    ST_REPLY,
    ST_DEL_START,
    ST_DEL,
    ST_DEL_END
  } state_t;

  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   hash;
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   key_len;
    logic [KEY_W-1:0]   holder;
    logic [LEN_W-1:0]   holder_len;
    logic [SINCE_W-1:0] since;
  } entry_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    r = (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    for (int b = 0; b < MAX_LEN; b++) begin
      m[8*b +: 8] = (len > LEN_W'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

>>> rtl/lta_req_if.sv
interface lta_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] key;
  logic [3:0]  key_len;
  logic [63:0] key_hash;
  logic [63:0] holder;
  logic [3:0]  holder_len;
  logic        force_req;
  logic [33:0] now_sec;

  modport source (output valid, mode, key, key_len, key_hash, holder, holder_len,
                  force_req, now_sec, input ready);
  modport sink (input valid, mode, key, key_len, key_hash, holder, holder_len,
                force_req, now_sec, output ready);
endinterface

>>> rtl/lta_rsp_if.sv
interface lta_rsp_if;
  logic              valid;
  logic              ready;
  lta_pkg::status_t  status;
  logic [63:0]       current_holder;
  logic [3:0]        current_holder_len;
  logic [33:0]       held_since;

  modport source (output valid, status, current_holder, current_holder_len, held_since,
                  input ready);
  modport sink (input valid, status, current_holder, current_holder_len, held_since,
                output ready);
endinterface

>>> rtl/lock_table_acquire_release.sv
// Channel  Role    Payload
// req      sink    mode, key, key_len, key_hash, holder, holder_len, force_req, now_sec
// rsp      source  status, current_holder, current_holder_len, held_since
//
// An item is accepted in IDLE, its home slot is read in LOOKUP, PROBE then walks the
// slots of its bank in order, and REPLY hands the result over once the output is free.
// A release that removes an entry then runs DEL_START, DEL over the shifted slots, DEL_END.
// After reset a clearing pass over all NUM_BANKS * SLOTS_PER_BANK slots empties the tables.
// The slot memory port (one read and one write per cycle) sets the probe rate.
// A new item is taken while the previous result still waits on rsp.
module lock_table_acquire_release #(
  parameter int NUM_BANKS      = 256,
  parameter int SLOTS_PER_BANK = 32
) (
  input logic       clk,
  input logic       rst,
  lta_req_if.sink   req,
  lta_rsp_if.source rsp
);

  // Both sizes are powers of two, so the bank and the home slot are low hash bits.
  localparam int TOTAL = NUM_BANKS * SLOTS_PER_BANK;
  localparam int AW    = $clog2(TOTAL);
  localparam int BIW   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int SIW   = $clog2(SLOTS_PER_BANK);
  localparam int CW    = $clog2(SLOTS_PER_BANK + 1);
  localparam int C4W   = CW + 2;
  localparam int ENW   = $bits(lta_pkg::entry_t);
  localparam int EW    = ENW + SIW;
  localparam int FULL_AT = 3 * SLOTS_PER_BANK;

  // Sequencer state.
  lta_pkg::state_t state, state_next;
  logic [AW-1:0]   clr;

  // The request being served.
  logic                              r_mode;
  logic [63:0]                       r_key;
  logic [3:0]                        r_klen;
  logic [63:0]                       r_hash;
  logic [63:0]                       r_holder;
  logic [3:0]                        r_hlen;
  logic                              r_force;
  logic [33:0]                       r_now;

  logic [SIW-1:0] idx, hole, j;
  logic [CW-1:0]  n;
  logic           del_pending;

  lta_pkg::status_t res_status;
  logic [63:0]      res_holder;
  logic [3:0]       res_hlen;
  logic [33:0]      res_since;

  logic             out_valid;
  lta_pkg::status_t o_status;
  logic [63:0]      o_holder;
  logic [3:0]       o_hlen;
  logic [33:0]      o_since;

  // Memory ports.
  logic                 s_we, s_re;
  logic [AW-1:0]        s_waddr, s_raddr;
  logic [EW-1:0]        s_wdata, s_rdata;
  logic                 c_we, c_re;
  logic [BIW-1:0]       c_waddr;
  logic [CW-1:0]        c_wdata, c_rdata;

  lta_pkg::entry_t rd_e, new_e;
  logic [SIW-1:0]  rd_home;
  logic [BIW-1:0]  bank;
  logic [SIW-1:0]  home;

  // Decision made when the probe ends.
  logic             dec_done;
  logic             dec_del;
  lta_pkg::status_t dec_status;
  logic [63:0]      dec_holder;
  logic [3:0]       dec_hlen;
  logic [33:0]      dec_since;

  logic hit, same_holder, full, displaced, last_probe, out_free;
  logic [SIW-1:0] idx_inc, hole_inc, j_inc;

  function automatic logic [AW-1:0] slot_addr(input logic [BIW-1:0] b,
                                              input logic [SIW-1:0] i);
    logic [AW-1:0] a;
    a = AW'(b) * AW'(SLOTS_PER_BANK) + AW'(i);
    return a;
  endfunction

  function automatic logic [SIW-1:0] wrap_inc(input logic [SIW-1:0] i);
    logic [SIW-1:0] r;
    r = (i == SIW'(SLOTS_PER_BANK - 1)) ? '0 : i + SIW'(1);
    return r;
  endfunction

  lta_ram #(.WIDTH(EW), .DEPTH(TOTAL)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  lta_ram #(.WIDTH(CW), .DEPTH(NUM_BANKS)) u_count_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(bank), .rdata(c_rdata)
  );

  assign rd_e    = lta_pkg::entry_t'(s_rdata[ENW-1:0]);
  assign rd_home = s_rdata[EW-1 -: SIW];
  assign bank    = r_hash[BIW-1:0] & BIW'(NUM_BANKS - 1);
  assign home    = r_hash[SIW-1:0];
  assign idx_inc  = wrap_inc(idx);
  assign hole_inc = wrap_inc(hole);
  assign j_inc    = wrap_inc(j);
  assign out_free = !out_valid || rsp.ready;

  assign hit = rd_e.used && rd_e.hash == r_hash && rd_e.key_len == r_klen &&
               rd_e.key == r_key;
  assign same_holder = rd_e.holder_len == r_hlen && rd_e.holder == r_holder;
  assign full = (C4W'(c_rdata) << 2) >= C4W'(FULL_AT);
  assign last_probe = n == CW'(SLOTS_PER_BANK - 1);

  // An entry may fill the hole when its home does not lie cyclically after the hole and at or before j.
  always_comb begin
    if (j >= hole) begin
      displaced = rd_home <= hole || rd_home > j;
    end else begin
      displaced = rd_home <= hole && rd_home > j;
    end
  end

  always_comb begin
    new_e            = rd_e;
    new_e.holder     = r_holder;
    new_e.holder_len = r_hlen;
    new_e.since      = r_now;
  end

  always_comb begin
    state_next = state;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0;
    s_re = 1'b0; s_raddr = '0;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0;
    c_re = 1'b0;
    dec_done = 1'b0; dec_del = 1'b0;
    dec_status = lta_pkg::STATUS_NOT_FOUND;
    dec_holder = '0; dec_hlen = '0; dec_since = '0;
    req.ready = 1'b0;
    case (state)
      lta_pkg::ST_CLEAR: begin
        s_we = 1'b1;
        s_waddr = clr;
        if (clr < AW'(NUM_BANKS)) begin
          c_we = 1'b1;
          c_waddr = clr[BIW-1:0];
        end
        if (clr == AW'(TOTAL - 1)) begin
          state_next = lta_pkg::ST_IDLE;
        end
      end
      lta_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = lta_pkg::ST_LOOKUP;
        end
      end
      lta_pkg::ST_LOOKUP: begin
        s_re = 1'b1;
        s_raddr = slot_addr(bank, home);
        c_re = 1'b1;
        state_next = lta_pkg::ST_PROBE;
      end
      lta_pkg::ST_PROBE: begin
        if (hit) begin
          dec_done = 1'b1;
          dec_holder = rd_e.holder;
          dec_hlen = rd_e.holder_len;
          dec_since = rd_e.since;
          if (r_mode == lta_pkg::MODE_ACQUIRE) begin
            if (same_holder) begin
              dec_status = lta_pkg::STATUS_ACQUIRED;
            end else if (!r_force) begin
              dec_status = lta_pkg::STATUS_CONFLICT;
            end else begin
              dec_status = lta_pkg::STATUS_ACQUIRED;
              dec_holder = r_holder;
              dec_hlen = r_hlen;
              dec_since = r_now;
              s_we = 1'b1;
              s_waddr = slot_addr(bank, idx);
              s_wdata = {rd_home, new_e};
            end
          end else if (same_holder) begin
            dec_status = lta_pkg::STATUS_RELEASED;
            dec_del = 1'b1;
          end else begin
            dec_status = lta_pkg::STATUS_FORBIDDEN;
          end
        end else if (!rd_e.used || last_probe) begin
          dec_done = 1'b1;
          if (r_mode == lta_pkg::MODE_RELEASE) begin
            dec_status = lta_pkg::STATUS_NOT_FOUND;
          end else if (full || rd_e.used) begin
            dec_status = lta_pkg::STATUS_TABLE_FULL;
          end else begin
            dec_status = lta_pkg::STATUS_ACQUIRED;
            dec_holder = r_holder;
            dec_hlen = r_hlen;
            dec_since = r_now;
            s_we = 1'b1;
            s_waddr = slot_addr(bank, idx);
            s_wdata = {home, 1'b1, r_hash, r_key, r_klen, r_holder, r_hlen, r_now};
            c_we = 1'b1;
            c_waddr = bank;
            c_wdata = c_rdata + CW'(1);
          end
        end else begin
          s_re = 1'b1;
          s_raddr = slot_addr(bank, idx_inc);
        end
        if (dec_done) begin
          state_next = lta_pkg::ST_REPLY;
        end
      end
      lta_pkg::ST_REPLY: begin
        if (out_free) begin
          state_next = del_pending ? lta_pkg::ST_DEL_START : lta_pkg::ST_IDLE;
        end
      end
      lta_pkg::ST_DEL_START: begin
        s_re = 1'b1;
        s_raddr = slot_addr(bank, hole_inc);
        state_next = lta_pkg::ST_DEL;
      end
      lta_pkg::ST_DEL: begin
        if (!rd_e.used) begin
          state_next = lta_pkg::ST_DEL_END;
        end else begin
          if (displaced) begin
            s_we = 1'b1;
            s_waddr = slot_addr(bank, hole);
            s_wdata = s_rdata;
          end
          if (last_probe) begin
            state_next = lta_pkg::ST_DEL_END;
          end else begin
            s_re = 1'b1;
            s_raddr = slot_addr(bank, j_inc);
          end
        end
      end
      lta_pkg::ST_DEL_END: begin
        s_we = 1'b1;
        s_waddr = slot_addr(bank, hole);
        c_we = 1'b1;
        c_waddr = bank;
        c_wdata = (c_rdata != '0) ? c_rdata - CW'(1) : c_rdata;
        state_next = lta_pkg::ST_IDLE;
      end
      default: begin
        state_next = lta_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lta_pkg::ST_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      del_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lta_pkg::ST_CLEAR) begin
        clr <= clr + AW'(1);
      end
      if (state == lta_pkg::ST_PROBE && dec_done) begin
        del_pending <= dec_del;
      end else if (state == lta_pkg::ST_DEL_START) begin
        del_pending <= 1'b0;
      end
      if (state == lta_pkg::ST_REPLY && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      lta_pkg::ST_IDLE: begin
        r_mode   <= req.mode;
        r_klen   <= lta_pkg::sat_len(req.key_len);
        r_key    <= req.key & lta_pkg::byte_mask(lta_pkg::sat_len(req.key_len));
        r_hash   <= req.key_hash;
        r_hlen   <= lta_pkg::sat_len(req.holder_len);
        r_holder <= req.holder & lta_pkg::byte_mask(lta_pkg::sat_len(req.holder_len));
        r_force  <= req.force_req;
        r_now    <= req.now_sec;
      end
      lta_pkg::ST_LOOKUP: begin
        idx <= home;
        n   <= '0;
      end
      lta_pkg::ST_PROBE: begin
        if (dec_done) begin
          res_status <= dec_status;
          res_holder <= dec_holder;
          res_hlen   <= dec_hlen;
          res_since  <= dec_since;
          hole       <= idx;
        end else begin
          idx <= idx_inc;
          n   <= n + CW'(1);
        end
      end
      lta_pkg::ST_REPLY: begin
        if (out_free) begin
          o_status <= res_status;
          o_holder <= res_holder;
          o_hlen   <= res_hlen;
          o_since  <= res_since;
        end
      end
      lta_pkg::ST_DEL_START: begin
        j <= hole_inc;
        n <= CW'(1);
      end
      lta_pkg::ST_DEL: begin
        if (rd_e.used && displaced) begin
          hole <= j;
        end
        j <= j_inc;
        n <= n + CW'(1);
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid              = out_valid;
  assign rsp.status             = o_status;
  assign rsp.current_holder     = o_holder;
  assign rsp.current_holder_len = o_hlen;
  assign rsp.held_since         = o_since;

endmodule

>>> rtl/lta_ram.sv
module lta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lta_checker.sv
`include "lock_table_acquire_release_macros.svh"

module lta_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic [63:0] current_holder,
  input logic [3:0]  holder_len,
  input logic [33:0] held_since
);

  `LTA_ASSERT_ALWAYS(a_reset_quiet, rst |=> !rsp_valid, "result shown right after reset")
  `LTA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "stalled result dropped")
  `LTA_ASSERT(a_rsp_range, rsp_valid |-> status <= 3'(lta_pkg::STATUS_TABLE_FULL) && holder_len <= 4'd8, "result field out of range")
  `LTA_ASSERT(a_empty_report, rsp_valid && (status == 3'(lta_pkg::STATUS_NOT_FOUND) || status == 3'(lta_pkg::STATUS_TABLE_FULL)) |-> current_holder == 64'd0 && holder_len == 4'd0 && held_since == 34'd0, "entry fields set without an entry")

endmodule

bind lock_table_acquire_release lta_checker u_lta_checker (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .status(rsp.status),
  .current_holder(rsp.current_holder),
  .holder_len(rsp.current_holder_len),
  .held_since(rsp.held_since)
);

>>> tb/sv/tb_lock_table_acquire_release.sv
`timescale 1ns / 100ps

module tb_lock_table_acquire_release;

  localparam int BANKS = 256;
  localparam int SLOTS = 32;
  localparam int POOL_N = 40;
  localparam int HOLDER_N = 4;

  // One lock request as the sender offers it.
  typedef struct {
    logic        mode;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [63:0] key_hash;
    logic [63:0] holder;
    logic [3:0]  holder_len;
    logic        force_req;
    logic [33:0] now_sec;
  } lock_req_t;

  // One expected answer from the lock table.
  typedef struct {
    lta_pkg::status_t status;
    logic [63:0]      holder;
    logic [3:0]       holder_len;
    logic [33:0]      since;
  } lock_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lta_req_if req ();
  lta_rsp_if rsp ();

  lock_table_acquire_release dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  // Requests waiting to be offered, and answers the table still owes us.
  lock_req_t pending_reqs[$];
  lock_rsp_t owed_answers[$];

  int accepted_cnt = 0;
  int answered_cnt = 0;
  int mismatch_cnt = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;

  // Shadow copy of the slot tables, kept in step with every accepted request.
  bit          sh_used[BANKS*SLOTS];
  logic [63:0] sh_hash[BANKS*SLOTS];
  logic [63:0] sh_key[BANKS*SLOTS];
  logic [3:0]  sh_key_len[BANKS*SLOTS];
  logic [63:0] sh_holder[BANKS*SLOTS];
  logic [3:0]  sh_holder_len[BANKS*SLOTS];
  logic [33:0] sh_since[BANKS*SLOTS];
  int          sh_count[BANKS];

  // Keys of the random part; most of them land in one bank so that it fills up.
  logic [63:0] pool_key[POOL_N];
  logic [3:0]  pool_len[POOL_N];
  logic [63:0] pool_hash[POOL_N];
  logic [63:0] holder_val[HOLDER_N];
  logic [3:0]  holder_len_val[HOLDER_N];

  function automatic logic [63:0] low_bytes(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (len > b) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // Applies one request to the shadow tables and returns the answer it earns.
  function automatic lock_rsp_t apply_lock_request(input lock_req_t r);
    lock_rsp_t   a;
    logic [3:0]  klen, hlen;
    logic [63:0] k, hd;
    int          bank, base, idx, found, s, report, j, natural;
    bit          displaced;
    klen = (r.key_len > 8) ? 4'd8 : r.key_len;
    hlen = (r.holder_len > 8) ? 4'd8 : r.holder_len;
    k = r.key & low_bytes(klen);
    hd = r.holder & low_bytes(hlen);
    bank = int'(r.key_hash % BANKS);
    base = bank * SLOTS;
    found = -1;
    report = -1;
    idx = int'(r.key_hash % SLOTS);
    for (int n = 0; n < SLOTS; n++) begin
      s = base + idx;
      if (!sh_used[s]) break;
      if (sh_hash[s] == r.key_hash && sh_key_len[s] == klen && sh_key[s] == k) begin
        found = idx;
        break;
      end
      idx = (idx + 1) % SLOTS;
    end

    if (r.mode == lta_pkg::MODE_ACQUIRE) begin
      if (found >= 0) begin
        s = base + found;
        report = s;
        if (sh_holder_len[s] == hlen && sh_holder[s] == hd) begin
          a.status = lta_pkg::STATUS_ACQUIRED;
        end else if (!r.force_req) begin
          a.status = lta_pkg::STATUS_CONFLICT;
        end else begin
          // A forced takeover hands the lock over and restamps it.
          sh_holder[s] = hd;
          sh_holder_len[s] = hlen;
          sh_since[s] = r.now_sec;
          a.status = lta_pkg::STATUS_ACQUIRED;
        end
      end else begin
        // A bank at three quarters load refuses new keys.
        a.status = lta_pkg::STATUS_TABLE_FULL;
        if (sh_count[bank] * 4 < SLOTS * 3) begin
          idx = int'(r.key_hash % SLOTS);
          for (int n = 0; n < SLOTS; n++) begin
            s = base + idx;
            if (!sh_used[s]) begin
              sh_used[s] = 1'b1;
              sh_hash[s] = r.key_hash;
              sh_key[s] = k;
              sh_key_len[s] = klen;
              sh_holder[s] = hd;
              sh_holder_len[s] = hlen;
              sh_since[s] = r.now_sec;
              sh_count[bank]++;
              report = s;
              a.status = lta_pkg::STATUS_ACQUIRED;
              break;
            end
            idx = (idx + 1) % SLOTS;
          end
        end
      end
    end else if (found < 0) begin
      a.status = lta_pkg::STATUS_NOT_FOUND;
    end else begin
      s = base + found;
      report = s;
      if (sh_holder_len[s] != hlen || sh_holder[s] != hd) a.status = lta_pkg::STATUS_FORBIDDEN;
      else a.status = lta_pkg::STATUS_RELEASED;
    end

    a.holder = '0;
    a.holder_len = '0;
    a.since = '0;
    if (report >= 0) begin
      a.holder = sh_holder[report];
      a.holder_len = sh_holder_len[report];
      a.since = sh_since[report];
    end

    // Release removes the entry and pulls later displaced entries back
    // toward their home slot so that probe chains stay unbroken.
    if (a.status == lta_pkg::STATUS_RELEASED) begin
      idx = found;
      j = (idx + 1) % SLOTS;
      sh_used[base + idx] = 1'b0;
      for (int n = 1; n < SLOTS; n++) begin
        if (!sh_used[base + j]) break;
        natural = int'(sh_hash[base + j] % SLOTS);
        if (j >= idx) displaced = (natural <= idx || natural > j);
        else displaced = (natural <= idx && natural > j);
        if (displaced) begin
          sh_used[base + idx] = 1'b1;
          sh_hash[base + idx] = sh_hash[base + j];
          sh_key[base + idx] = sh_key[base + j];
          sh_key_len[base + idx] = sh_key_len[base + j];
          sh_holder[base + idx] = sh_holder[base + j];
          sh_holder_len[base + idx] = sh_holder_len[base + j];
          sh_since[base + idx] = sh_since[base + j];
          sh_used[base + j] = 1'b0;
          idx = j;
        end
        j = (j + 1) % SLOTS;
      end
      if (sh_count[bank] > 0) sh_count[bank]--;
    end
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [33:0] rand_now();
    return {2'($urandom_range(3, 0)), $urandom()};
  endfunction

  function automatic lock_req_t make_req(input logic mode, input logic [63:0] key,
                                         input logic [3:0] klen, input logic [63:0] hash,
                                         input logic [63:0] holder, input logic [3:0] hlen,
                                         input logic frc, input logic [33:0] now);
    lock_req_t r;
    r.mode = mode;
    r.key = key;
    r.key_len = klen;
    r.key_hash = hash;
    r.holder = holder;
    r.holder_len = hlen;
    r.force_req = frc;
    r.now_sec = now;
    return r;
  endfunction

  // Idle pattern follows the progress of the run: the receiver idles more at
  // first, then the sender, and the last stretch runs without gaps.
  function automatic int send_idle_pct();
    if (accepted_cnt < 160) return 35;
    if (accepted_cnt < 320) return 70;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_cnt < 160) return 70;
    if (accepted_cnt < 320) return 35;
    return 0;
  endfunction

  // Sender. A new item goes out only when the current one has been taken,
  // so valid and the payload are held until the item is taken.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct()) begin
        lock_req_t r;
        r = pending_reqs.pop_front();
        req.valid <= 1'b1;
        req.mode <= r.mode;
        req.key <= r.key;
        req.key_len <= r.key_len;
        req.key_hash <= r.key_hash;
        req.holder <= r.holder;
        req.holder_len <= r.holder_len;
        req.force_req <= r.force_req;
        req.now_sec <= r.now_sec;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Every accepted item updates the shadow tables and queues its answer.
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      owed_answers.push_back(apply_lock_request(make_req(req.mode, req.key, req.key_len,
          req.key_hash, req.holder, req.holder_len, req.force_req, req.now_sec)));
      accepted_cnt <= accepted_cnt + 1;
    end
  end

  // Receiver. Once, early in the run, it holds off for a long stretch while
  // the sender keeps offering, so the table backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 40) begin
      hold_done <= 1'b1;
      hold_cycles <= 400;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct());
    end
  end

  // Answer checker: each answer is matched against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (owed_answers.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10)
          $display("answer with nothing owed: status %0d", rsp.status);
      end else begin
        lock_rsp_t e;
        e = owed_answers.pop_front();
        if (rsp.status !== e.status || rsp.current_holder !== e.holder ||
            rsp.current_holder_len !== e.holder_len || rsp.held_since !== e.since) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("answer %0d: expected %0d/%h/%0d/%h got %0d/%h/%0d/%h",
                     answered_cnt, e.status, e.holder, e.holder_len, e.since,
                     rsp.status, rsp.current_holder, rsp.current_holder_len,
                     rsp.held_since);
        end
      end
      answered_cnt <= answered_cnt + 1;
    end
  end

  initial begin
    logic [63:0] ka, ha, h1, h2;
    int p, hi;
    req.valid = 1'b0;
    req.mode = lta_pkg::MODE_ACQUIRE;
    req.key = '0;
    req.key_len = 4'd1;
    req.key_hash = '0;
    req.holder = '0;
    req.holder_len = '0;
    req.force_req = 1'b0;
    req.now_sec = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < BANKS*SLOTS; i++) sh_used[i] = 1'b0;
    for (int i = 0; i < BANKS; i++) sh_count[i] = 0;

    // Holders differ in length as well as bytes; one is empty.
    holder_val[0] = rand64(); holder_len_val[0] = 4'd8;
    holder_val[1] = rand64(); holder_len_val[1] = 4'd3;
    holder_val[2] = rand64(); holder_len_val[2] = 4'd0;
    holder_val[3] = holder_val[1]; holder_len_val[3] = 4'd5;

    // Thirty keys share bank 7, enough to push it past its load limit.
    // Some pairs share a hash, so only the key bytes and lengths tell them apart.
    for (int i = 0; i < POOL_N; i++) begin
      pool_key[i] = rand64();
      pool_len[i] = 4'($urandom_range(15, 0));
      pool_hash[i] = rand64();
      pool_hash[i][7:0] = (i < 30) ? 8'd7 : 8'($urandom_range(255, 0));
      if (i % 5 == 1) pool_hash[i] = pool_hash[i-1];
    end

    // Directed part: the basic lock life cycle and the edges of the fields.
    ka = 64'h0123_4567_89AB_CDEF;
    ha = 64'hFFFF_FFFF_FFFF_FF00;
    h1 = 64'hFFFF_FFFF_FFFF_FFFF;
    h2 = 64'h0000_0000_0000_0001;
    pending_reqs.push_back(make_req(lta_pkg::MODE_RELEASE, ka, 4'd8, ha, h1, 4'd8, 1'b0,
                                    34'd5));
    pending_reqs.push_back(make_req(lta_pkg::MODE_ACQUIRE, ka, 4'd8, ha, h1, 4'd8, 1'b0,
                                    34'd10));
    pending_reqs.push_back(make_req(lta_pkg::MODE_ACQUIRE, ka, 4'd8, ha, h1, 4'd8, 1'b0,
                                    34'd20));
    pending_reqs.push_back(make_req(lta_pkg::MODE_ACQUIRE, ka, 4'd8, ha, h2, 4'd1, 1'b0,
                                    34'd30));
    pending_reqs.push_back(make_req(lta_pkg::MODE_RELEASE, ka, 4'd8, ha, h2, 4'd1, 1'b0,
                                    34'd31));
    pending_reqs.push_back(make_req(lta_pkg::MODE_ACQUIRE, ka, 4'd8, ha, h2, 4'd1, 1'b1,
                                    34'h3_FFFF_FFFF));
    pending_reqs.push_back(make_req(lta_pkg::MODE_RELEASE, ka, 4'd8, ha, h1, 4'd8, 1'b0,
                                    34'd40));
    pending_reqs.push_back(make_req(lta_pkg::MODE_RELEASE, ka, 4'd8, ha, h2, 4'd1, 1'b0,
                                    34'd41));
    // Lengths above eight behave as eight; bytes above a length are ignored.
    pending_reqs.push_back(make_req(lta_pkg::MODE_ACQUIRE, ka, 4'd15, ha, h1, 4'd12, 1'b0,
                                    34'd50));
    pending_reqs.push_back(make_req(lta_pkg::MODE_ACQUIRE, ka, 4'd8, ha, h1, 4'd8, 1'b0,
                                    34'd51));
    pending_reqs.push_back(make_req(lta_pkg::MODE_RELEASE, ka, 4'd9, ha, h1, 4'd15, 1'b0,
                                    34'd52));
    // Zero key length and an empty holder; a same-hash key of another length.
    pending_reqs.push_back(make_req(lta_pkg::MODE_ACQUIRE, h1, 4'd0, 64'd0, h1, 4'd0, 1'b0,
                                    34'd60));
    pending_reqs.push_back(make_req(lta_pkg::MODE_ACQUIRE, 64'd0, 4'd1, 64'd0, h2, 4'd0,
                                    1'b0, 34'd61));
    pending_reqs.push_back(make_req(lta_pkg::MODE_ACQUIRE, 64'd0, 4'd0, 64'd0, 64'd0, 4'd0,
                                    1'b0, 34'd62));
    pending_reqs.push_back(make_req(lta_pkg::MODE_RELEASE, 64'd0, 4'd0, 64'd0, 64'd0, 4'd1,
                                    1'b0, 34'd63));
    // Releasing the head of a chain shifts the second entry back home.
    pending_reqs.push_back(make_req(lta_pkg::MODE_RELEASE, 64'h55, 4'd0, 64'd0, 64'hAA,
                                    4'd0, 1'b0, 34'd64));
    pending_reqs.push_back(make_req(lta_pkg::MODE_RELEASE, 64'd0, 4'd1, 64'd0, h2, 4'd0,
                                    1'b0, 34'd65));
    pending_reqs.push_back(make_req(lta_pkg::MODE_RELEASE, 64'd0, 4'd1, 64'd0, h2, 4'd0,
                                    1'b0, 34'd66));

    // Random part: mostly acquires and releases of pooled keys so the hot
    // bank fills, conflicts and shifts; a share of fully random requests.
    for (int i = 0; i < 440; i++) begin
      p = $urandom_range(POOL_N - 1, 0);
      hi = $urandom_range(HOLDER_N - 1, 0);
      if ($urandom_range(99, 0) < 85) begin
        pending_reqs.push_back(make_req($urandom_range(99, 0) < 45, pool_key[p] ^
            (rand64() & ~low_bytes(pool_len[p])), pool_len[p], pool_hash[p],
            holder_val[hi] ^ (rand64() & ~low_bytes(holder_len_val[hi])),
            holder_len_val[hi], $urandom_range(3, 0) == 0, rand_now()));
      end else begin
        pending_reqs.push_back(make_req(1'($urandom_range(1, 0)), rand64(),
            4'($urandom_range(15, 0)), rand64(), rand64(), 4'($urandom_range(15, 0)),
            1'($urandom_range(1, 0)), rand_now()));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (pending_reqs.size() == 0 && !req.valid && owed_answers.size() == 0);
    // Let any stray answer show up before the verdict.
    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0 && owed_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: the clearing pass, 458 items under heavy stalls, and the long
  // hold-off fit many times over.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
